### hdl/csrsm_pkg.sv
// Shared types and codes for the compressed sparse row store.
`timescale 1ns / 1ps
package csrsm_pkg;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 16;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             bump;
    logic [ROW_W-1:0] row;
  } row_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROWS = 4'b0010,
    ST_ENTS = 4'b0100,
    ST_BUMP = 4'b1000
  } state_t;

endpackage

### hdl/csrsm_row_cell.sv
// One row start pointer cell of the pointer ring.
`timescale 1ns / 1ps
module csrsm_row_cell #(
  parameter int IDX = 0,
  parameter int PW  = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  csrsm_pkg::row_ctl_t ctl,
  input  logic [PW-1:0]       din,
  output logic [PW-1:0]       dout
);
  import csrsm_pkg::*;

  logic [PW-1:0] ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctl.shift) begin
      ptr <= din;
    end else if (ctl.bump && (IDX > int'(ctl.row))) begin
      // rows after the insert start one entry later
      ptr <= ptr + 1'b1;
    end
  end

  assign dout = ptr;

endmodule

### hdl/csrsm_entry_cell.sv
// One stored entry cell (column and value) of the entry ring.
`timescale 1ns / 1ps
module csrsm_entry_cell (
  input  logic              clk,
  input  logic              shift,
  input  csrsm_pkg::entry_t din,
  output csrsm_pkg::entry_t dout
);
  import csrsm_pkg::*;

  entry_t ent;

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= din;
    end
  end

  assign dout = ent;

endmodule

### hdl/csr_sparse_matrix_store.sv
// Top level: compressed sparse row store with ring-shaped pointer and entry chains.
//
//  channel   | beat marked by        | fields
//  ----------+-----------------------+-----------------------------------
//  command   | start & !busy         | command, row, col, write_value
//  result    | done (one cycle)      | status, read_value
//  config    | cfg_write             | cfg_index, cfg_data
//
// An in-range command runs from accept to done through one full turn of the pointer
// ring, one full turn of the entry ring and the bump state.
// An out-of-range command answers on the cycle after accept.
// Reset clears the pointers, the entry count and the control; entry contents
// stay undefined until written. The receiver cannot stall; busy holds off start.
`timescale 1ns / 1ps
module csr_sparse_matrix_store #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 65536,
  parameter int CAPACITY = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [csrsm_pkg::ROW_W-1:0]       row,
  input  logic [csrsm_pkg::COL_W-1:0]       col,
  input  logic signed [csrsm_pkg::VAL_W-1:0] write_value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [csrsm_pkg::VAL_W-1:0] read_value,
  input  logic                              cfg_write,
  input  logic [csrsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csrsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import csrsm_pkg::*;

  localparam int PW  = $clog2(CAPACITY + 1);
  localparam int RN  = MAX_ROWS + 1;
  localparam int RCW = $clog2(RN + 1);

  state_t state;

  logic [6:0]        row_count;
  logic [16:0]       col_count;
  logic [PW-1:0]     entry_count;

  logic              cmd_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic [VAL_W-1:0]  val_q;

  logic [RCW-1:0]    rstep;
  logic [PW-1:0]     estep;
  logic [PW-1:0]     lo_raw, hi_raw;
  logic [PW-1:0]     lo, hi;

  logic              matched, inserted, carry_active;
  entry_t            carry;
  entry_t            feed;
  logic [VAL_W-1:0]  rd_hold;

  row_ctl_t          row_ctl;
  logic [PW-1:0]     rp  [RN];
  entry_t            ent [CAPACITY];

  logic              in_range, in_row, full, settled, take_match, take_insert;

  // ring of row start pointers; cell 0 is the head seen by the controller
  assign row_ctl.shift = (state == ST_ROWS);
  assign row_ctl.bump  = (state == ST_BUMP) && inserted;
  assign row_ctl.row   = row_q;

  for (genvar k = 0; k < RN; k++) begin : g_row
    csrsm_row_cell #(.IDX(k), .PW(PW)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (row_ctl),
      .din  ((k == RN - 1) ? rp[0] : rp[(k + 1) % RN]),
      .dout (rp[k])
    );
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_ent
    csrsm_entry_cell u_cell (
      .clk   (clk),
      .shift (state == ST_ENTS),
      .din   ((k == CAPACITY - 1) ? feed : ent[(k + 1) % CAPACITY]),
      .dout  (ent[k])
    );
  end

  assign busy = (state != ST_IDLE);

  assign in_range = ({1'b0, row} < row_count) && (32'(row) < 32'(MAX_ROWS)) &&
                    ({1'b0, col} < col_count) && (32'(col) < 32'(MAX_COLS));

  assign hi = (hi_raw > entry_count) ? entry_count : hi_raw;
  assign lo = (lo_raw > hi) ? hi : lo_raw;

  assign in_row  = (estep >= lo) && (estep < hi);
  assign full    = (entry_count >= PW'(CAPACITY));
  assign settled = matched || carry_active;

  assign take_match  = !settled && in_row && (ent[0].col == col_q);
  assign take_insert = !settled && !take_match && (cmd_q == CMD_WRITE) && !full &&
                       ((in_row && (ent[0].col > col_q)) || (estep == hi));

  // the tail takes the new entry, a held-back entry, or the head going round
  always_comb begin
    feed = ent[0];
    if (carry_active) begin
      feed = carry;
    end
    if ((take_match && (cmd_q == CMD_WRITE)) || take_insert) begin
      feed.col = col_q;
      feed.val = val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      row_count   <= 7'd64;
      col_count   <= 17'd65536;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT: row_count <= cfg_data[6:0];
          REG_COL_COUNT: col_count <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q <= command;
            row_q <= row;
            col_q <= col;
            val_q <= write_value;
            if (in_range) begin
              state <= ST_ROWS;
              rstep <= '0;
            end else begin
              done       <= 1'b1;
              status     <= STAT_RANGE;
              read_value <= '0;
            end
          end
        end
        ST_ROWS: begin
          if (rstep == RCW'(int'(row_q))) lo_raw <= rp[0];
          if (rstep == RCW'(int'(row_q) + 1)) hi_raw <= rp[0];
          rstep <= rstep + 1'b1;
          if (rstep == RCW'(RN - 1)) begin
            state        <= ST_ENTS;
            estep        <= '0;
            matched      <= 1'b0;
            inserted     <= 1'b0;
            carry_active <= 1'b0;
            rd_hold      <= '0;
          end
        end
        ST_ENTS: begin
          if (carry_active || take_insert) carry <= ent[0];
          if (take_insert) begin
            carry_active <= 1'b1;
            inserted     <= 1'b1;
          end
          if (take_match) begin
            matched <= 1'b1;
            if (cmd_q == CMD_READ) rd_hold <= ent[0].val;
          end
          estep <= estep + 1'b1;
          if (estep == PW'(CAPACITY - 1)) state <= ST_BUMP;
        end
        ST_BUMP: begin
          if (inserted) entry_count <= entry_count + 1'b1;
          done       <= 1'b1;
          read_value <= rd_hold;
          status     <= ((cmd_q == CMD_WRITE) && !matched && !inserted) ? STAT_FULL : STAT_OK;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_BUMP || (state == ST_IDLE && start)))
    else $error("result strobe without a finished command");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (read_value == '0))
    else $error("failed command returned a value");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= PW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_single_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ENTS && carry_active) |-> (inserted && !matched))
    else $error("insert and match in one command");

endmodule
